// ----- rtl/core/cfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the ring FIFO with unique insert.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // ring store geometry
  localparam int DEPTH  = 256;
  localparam int DATA_W = 8;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  // remainder unit: dividend covers head plus a count or position
  localparam int DIV_W     = CNT_W;
  localparam int STEP_W    = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

  localparam logic [CNT_W-1:0] SIZE_MAX   = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(DEPTH);

  // request codes
  typedef enum logic [2:0] {
    FN_ENQ      = 3'd0,
    FN_ENQ_UNIQ = 3'd1,
    FN_DEQ      = 3'd2,
    FN_PEEK     = 3'd3,
    FN_PEEK_POS = 3'd4,
    FN_CLEAR    = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_DUP     = 3'd3,
    ST_BAD_POS = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MOD   = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_CMP   = 8'b0000_1000,
    S_WRITE = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_RDATA = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/circular_fifo_with_dedup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// circular_fifo_with_dedup
// Byte FIFO in a ring store with a configurable capacity and unique insert.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives exactly one result transaction.
// Every request that touches the ring first reduces a ring offset modulo the
// configured size in a shared remainder unit of nine shift-subtract steps,
// then uses the single-port store: enqueue writes it, dequeue and peek read
// it through the registered store read. Unique insert compares the held
// entries one at a time, each through the registered store read, and writes
// only if none matches and room is left. Clear, empty, full-on-plain enqueue,
// bad position and the unused codes skip the remainder unit. A new
// request is accepted as soon as the sequencer is idle, even while the
// previous result waits in the output register. The size register may be
// written at any time the block holds no request in flight.
// ----------------------------------------------------------------------------
module circular_fifo_with_dedup (
  input  wire                        clk,
  input  wire                        rst,
  // configuration
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [cfd_pkg::CNT_W-1:0]   queue_size,
  // request channel
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire [2:0]                  func,
  input  wire [cfd_pkg::DATA_W-1:0]  item_value,
  input  wire [cfd_pkg::CNT_W-1:0]   position,
  // result channel
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [2:0]                 status,
  output logic [cfd_pkg::DATA_W-1:0] read_value,
  output logic [cfd_pkg::CNT_W-1:0]  fill_count,
  output logic [cfd_pkg::CNT_W-1:0]  free_space
);
  import cfd_pkg::*;

  // ring store
  logic [DATA_W-1:0] ring [DEPTH];
  logic [DATA_W-1:0] rd_data;

  // architectural state
  logic [CNT_W-1:0]  size_cfg;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;

  // request context
  state_t            state;
  func_t             func_q;
  logic [DATA_W-1:0] item_q;
  logic [CNT_W-1:0]  size_q;
  status_t           status_q;
  logic [DATA_W-1:0] rd_val;
  logic [ADDR_W-1:0] slot;
  logic [CNT_W-1:0]  walk_k;

  // remainder unit
  logic [DIV_W-1:0]  mod_num;
  logic [CNT_W-1:0]  mod_rem;
  logic [STEP_W-1:0] mod_cnt;
  logic [CNT_W-1:0]  mod_trial;
  logic [CNT_W-1:0]  mod_step;

  // decode of the new request
  logic [CNT_W-1:0]  size_eff;
  func_t             func_in;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  slot_inc;
  logic              in_fire;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign func_in   = func_t'(func);
  assign pos_m1    = position - CNT_W'(1);
  assign slot_inc  = {1'b0, slot} + CNT_W'(1);

  // size register as used: zero acts as one, above depth acts as depth
  always_comb begin
    if (size_cfg == '0) begin
      size_eff = CNT_W'(1);
    end else if (size_cfg > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = size_cfg;
    end
  end

  // one shift-subtract step of the remainder
  always_comb begin
    mod_trial = {mod_rem[CNT_W-2:0], mod_num[DIV_W-1]};
    if (mod_trial >= size_q) begin
      mod_step = mod_trial - size_q;
    end else begin
      mod_step = mod_trial;
    end
  end

  // store access: registered read at the current slot
  always_ff @(posedge clk) begin
    rd_data <= ring[slot];
    if (state == S_WRITE) begin
      ring[slot] <= item_q;
    end
  end

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg <= queue_size;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result leaves when taken, unless a new one is loaded
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            func_q   <= func_in;
            item_q   <= item_value;
            size_q   <= size_eff;
            rd_val   <= '0;
            walk_k   <= '0;
            mod_rem  <= '0;
            mod_cnt  <= '0;
            case (func_in)
              FN_ENQ: begin
                if (count >= size_eff) begin
                  status_q <= ST_FULL;
                  state    <= S_DONE;
                end else begin
                  status_q <= ST_OK;
                  mod_num  <= DIV_W'({1'b0, head}) + count;
                  state    <= S_MOD;
                end
              end
              FN_ENQ_UNIQ: begin
                status_q <= ST_OK;
                mod_num  <= DIV_W'({1'b0, head});
                state    <= S_MOD;
              end
              FN_DEQ, FN_PEEK: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  state    <= S_DONE;
                end else begin
                  status_q <= ST_OK;
                  mod_num  <= DIV_W'({1'b0, head});
                  state    <= S_MOD;
                end
              end
              FN_PEEK_POS: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  state    <= S_DONE;
                end else if (position == '0 || position > count) begin
                  status_q <= ST_BAD_POS;
                  state    <= S_DONE;
                end else begin
                  status_q <= ST_OK;
                  mod_num  <= DIV_W'({1'b0, head}) + pos_m1;
                  state    <= S_MOD;
                end
              end
              FN_CLEAR: begin
                head     <= '0;
                count    <= '0;
                status_q <= ST_OK;
                state    <= S_DONE;
              end
              default: begin
                status_q <= ST_OK;
                state    <= S_DONE;
              end
            endcase
          end
        end

        // ring offset modulo size, one bit per cycle
        S_MOD: begin
          mod_rem <= mod_step;
          mod_num <= {mod_num[DIV_W-2:0], 1'b0};
          mod_cnt <= mod_cnt + STEP_W'(1);
          if (mod_cnt == LAST_STEP) begin
            slot <= mod_step[ADDR_W-1:0];
            case (func_q)
              FN_ENQ:      state <= S_WRITE;
              FN_ENQ_UNIQ: state <= S_WALK;
              default:     state <= S_READ;
            endcase
          end
        end

        // walk held entries; slot ends on the tail slot
        S_WALK: begin
          if (walk_k == count) begin
            if (count >= size_q) begin
              status_q <= ST_FULL;
              state    <= S_DONE;
            end else begin
              state <= S_WRITE;
            end
          end else begin
            state <= S_CMP;
          end
        end

        S_CMP: begin
          if (rd_data == item_q) begin
            status_q <= ST_DUP;
            state    <= S_DONE;
          end else begin
            slot   <= (slot_inc == size_q) ? '0 : slot_inc[ADDR_W-1:0];
            walk_k <= walk_k + CNT_W'(1);
            state  <= S_WALK;
          end
        end

        S_WRITE: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end

        S_READ: begin
          state <= S_RDATA;
        end

        S_RDATA: begin
          rd_val <= rd_data;
          if (func_q == FN_DEQ) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              head <= '0;
            end else begin
              head <= (slot_inc == size_q) ? '0 : slot_inc[ADDR_W-1:0];
            end
          end
          state <= S_DONE;
        end

        // hand the result to the output register
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= status_q;
            read_value <= rd_val;
            fill_count <= count;
            free_space <= (size_q > count) ? (size_q - count) : '0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
